@@ hdl/mhpq_pkg.sv @@
// Package for the max-heap priority queue: widths, codes, controller state
// and the command/status structs between controller and datapath.
// No dependencies.
package mhpq_pkg;

    localparam int DEF_CAPACITY = 1024;
    localparam int KEY_W        = 32;
    localparam int STATUS_W     = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_LAST_RD,
        ST_DN_LOAD,
        ST_DN_RD,
        ST_DN_CMP
    } state_t;

    // Commands from controller to datapath, one step each
    typedef struct packed {
        logic accept;
        logic decide;
        logic up_rd;
        logic up_cmp;
        logic last_rd;
        logic dn_load;
        logic dn_rd;
        logic dn_cmp;
        logic fin;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_pop;
        logic full;
        logic empty;
        logic pos_zero;
        logic up_move;
        logic last_zero;
        logic dn_leaf;
        logic dn_move;
        logic out_busy;
    } stat_t;

endpackage

@@ hdl/mhpq_ctrl.sv @@
// Controller state machine of the max-heap priority queue.
// Depends on mhpq_pkg.
module mhpq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mhpq_pkg::stat_t stat,
    output mhpq_pkg::cmd_t  cmd
);

    mhpq_pkg::state_t state_reg;
    mhpq_pkg::state_t state_next;
    logic             fin_reg;
    logic             fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mhpq_pkg::ST_IDLE;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    // fin_reg: a finished item waits for the output register to free up
    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        if (fin_reg && !stat.out_busy)
        begin
            cmd.fin  = 1'b1;
            fin_next = 1'b0;
        end
        case (state_reg)
            mhpq_pkg::ST_IDLE:
            begin
                in_ready = !fin_reg;
                if (in_valid && !fin_reg)
                begin
                    cmd.accept = 1'b1;
                    state_next = mhpq_pkg::ST_DECIDE;
                end
            end
            mhpq_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (!stat.is_pop)
                begin
                    if (stat.full)
                    begin
                        fin_next   = 1'b1;
                        state_next = mhpq_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = mhpq_pkg::ST_UP_RD;
                    end
                end
                else if (stat.empty)
                begin
                    fin_next   = 1'b1;
                    state_next = mhpq_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = mhpq_pkg::ST_LAST_RD;
                end
            end
            mhpq_pkg::ST_UP_RD:
            begin
                cmd.up_rd = 1'b1;
                if (stat.pos_zero)
                begin
                    fin_next   = 1'b1;
                    state_next = mhpq_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = mhpq_pkg::ST_UP_CMP;
                end
            end
            mhpq_pkg::ST_UP_CMP:
            begin
                cmd.up_cmp = 1'b1;
                if (stat.up_move)
                begin
                    state_next = mhpq_pkg::ST_UP_RD;
                end
                else
                begin
                    fin_next   = 1'b1;
                    state_next = mhpq_pkg::ST_IDLE;
                end
            end
            mhpq_pkg::ST_LAST_RD:
            begin
                cmd.last_rd = 1'b1;
                if (stat.last_zero)
                begin
                    fin_next   = 1'b1;
                    state_next = mhpq_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = mhpq_pkg::ST_DN_LOAD;
                end
            end
            mhpq_pkg::ST_DN_LOAD:
            begin
                cmd.dn_load = 1'b1;
                state_next  = mhpq_pkg::ST_DN_RD;
            end
            mhpq_pkg::ST_DN_RD:
            begin
                cmd.dn_rd = 1'b1;
                if (stat.dn_leaf)
                begin
                    fin_next   = 1'b1;
                    state_next = mhpq_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = mhpq_pkg::ST_DN_CMP;
                end
            end
            mhpq_pkg::ST_DN_CMP:
            begin
                cmd.dn_cmp = 1'b1;
                if (stat.dn_move)
                begin
                    state_next = mhpq_pkg::ST_DN_RD;
                end
                else
                begin
                    fin_next   = 1'b1;
                    state_next = mhpq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mhpq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/mhpq_dp.sv @@
// Datapath of the max-heap priority queue: heap memory, hole position,
// moving key, entry count, root copy and output register.
// Depends on mhpq_pkg.
module mhpq_dp #(
    parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mhpq_pkg::cmd_t                      cmd,
    output mhpq_pkg::stat_t                     stat,
    input  logic                                opcode,
    input  logic signed [mhpq_pkg::KEY_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mhpq_pkg::STATUS_W-1:0]       status,
    output logic signed [mhpq_pkg::KEY_W-1:0]   top_value,
    output logic                                top_valid,
    output logic [$clog2(CAPACITY+1)-1:0]       entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [mhpq_pkg::KEY_W-1:0] mem [CAPACITY];
    logic signed [mhpq_pkg::KEY_W-1:0] rd_a_reg;
    logic signed [mhpq_pkg::KEY_W-1:0] rd_b_reg;
    logic [AW-1:0]                     ra_a;
    logic [AW-1:0]                     ra_b;
    logic                              we;
    logic signed [mhpq_pkg::KEY_W-1:0] wd;

    logic                              op_reg;
    logic signed [mhpq_pkg::KEY_W-1:0] key_reg;
    logic signed [mhpq_pkg::KEY_W-1:0] key_next;
    logic [AW-1:0]                     pos_reg;
    logic [AW-1:0]                     pos_next;
    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     count_next;
    logic [mhpq_pkg::STATUS_W-1:0]     code_reg;
    logic [mhpq_pkg::STATUS_W-1:0]     code_next;
    logic signed [mhpq_pkg::KEY_W-1:0] top_reg;

    logic                              out_valid_reg;
    logic [mhpq_pkg::STATUS_W-1:0]     status_reg;
    logic signed [mhpq_pkg::KEY_W-1:0] top_value_reg;
    logic                              top_valid_reg;
    logic [CW-1:0]                     entry_count_reg;

    logic [AW-1:0]                     parent;
    logic [CW:0]                       lc;
    logic [CW:0]                       rc;
    logic                              rc_ok;
    logic                              left_gt;
    logic                              right_gt;
    logic signed [mhpq_pkg::KEY_W-1:0] best_l;
    logic signed [mhpq_pkg::KEY_W-1:0] best_val;
    logic [AW-1:0]                     best_pos;
    logic                              full;
    logic                              empty;

    // Child and parent addresses of the hole
    assign parent   = (pos_reg - AW'(1)) >> 1;
    assign lc       = {(CW + 1 - AW)'(0), pos_reg} + {(CW + 1 - AW)'(0), pos_reg}
                      + (CW + 1)'(1);
    assign rc       = lc + (CW + 1)'(1);
    assign rc_ok    = rc < {1'b0, count_reg};
    assign left_gt  = rd_a_reg > key_reg;
    assign best_l   = left_gt ? rd_a_reg : key_reg;
    assign right_gt = rc_ok && (rd_b_reg > best_l);
    assign best_val = right_gt ? rd_b_reg : rd_a_reg;
    assign best_pos = right_gt ? rc[AW-1:0] : lc[AW-1:0];
    assign full     = count_reg >= CW'(CAPACITY);
    assign empty    = count_reg == '0;

    assign stat.is_pop    = op_reg == mhpq_pkg::OP_REMOVE;
    assign stat.full      = full;
    assign stat.empty     = empty;
    assign stat.pos_zero  = pos_reg == '0;
    assign stat.up_move   = rd_a_reg < key_reg;
    assign stat.last_zero = empty;
    assign stat.dn_leaf   = lc >= {1'b0, count_reg};
    assign stat.dn_move   = left_gt || right_gt;
    assign stat.out_busy  = out_valid_reg && !out_ready;

    // Memory ports and register updates per command
    always_comb
    begin
        ra_a       = lc[AW-1:0];
        ra_b       = rc[AW-1:0];
        we         = 1'b0;
        wd         = key_reg;
        key_next   = key_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        code_next  = code_reg;
        if (cmd.up_rd)
        begin
            ra_a = parent;
        end
        if (cmd.last_rd)
        begin
            ra_a = count_reg[AW-1:0];
        end
        if (cmd.accept)
        begin
            key_next = value;
        end
        if (cmd.decide)
        begin
            code_next = mhpq_pkg::STATUS_DONE;
            if (op_reg == mhpq_pkg::OP_INSERT)
            begin
                if (full)
                begin
                    code_next = mhpq_pkg::STATUS_FULL;
                end
                else
                begin
                    pos_next   = count_reg[AW-1:0];
                    count_next = count_reg + CW'(1);
                end
            end
            else if (empty)
            begin
                code_next = mhpq_pkg::STATUS_EMPTY;
            end
            else
            begin
                count_next = count_reg - CW'(1);
            end
        end
        if (cmd.up_rd && (pos_reg == '0))
        begin
            we = 1'b1;
        end
        if (cmd.up_cmp)
        begin
            we = 1'b1;
            if (rd_a_reg < key_reg)
            begin
                wd       = rd_a_reg;
                pos_next = parent;
            end
        end
        if (cmd.dn_load)
        begin
            key_next = rd_a_reg;
            pos_next = '0;
        end
        if (cmd.dn_rd && (lc >= {1'b0, count_reg}))
        begin
            we = 1'b1;
        end
        if (cmd.dn_cmp)
        begin
            we = 1'b1;
            if (left_gt || right_gt)
            begin
                wd       = best_val;
                pos_next = best_pos;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[pos_reg] <= wd;
        end
        rd_a_reg <= mem[ra_a];
        rd_b_reg <= mem[ra_b];
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pos_reg <= pos_next;
        if (cmd.accept)
        begin
            op_reg <= opcode;
        end
        code_reg <= code_next;
        // Keep a copy of the root for the result
        if (we && (pos_reg == '0))
        begin
            top_reg <= wd;
        end
        if (cmd.fin)
        begin
            status_reg      <= code_reg;
            top_value_reg   <= empty ? '0 : top_reg;
            top_valid_reg   <= !empty;
            entry_count_reg <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign top_value   = top_value_reg;
    assign top_valid   = top_valid_reg;
    assign entry_count = entry_count_reg;

endmodule

@@ hdl/max_heap_priority_queue_top.sv @@
// Max-heap priority queue, top level. A dropped insert or an ignored remove finishes
// in the decide state, removing the last entry in the last-read state; an insert
// climbs and a remove descends the heap, one read-compare-write round trip through
// the heap memory per level. A new word is taken only once the previous result has
// reached the output register. Reset clears count and control, not memory.
// Depends on mhpq_pkg, mhpq_ctrl and mhpq_dp.
module max_heap_priority_queue_top #(
    parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel: one word is one insert or remove request
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                opcode,
    input  logic signed [mhpq_pkg::KEY_W-1:0]   value,
    // output channel: one result word per request
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mhpq_pkg::STATUS_W-1:0]       status,
    output logic signed [mhpq_pkg::KEY_W-1:0]   top_value,
    output logic                                top_valid,
    output logic [$clog2(CAPACITY+1)-1:0]       entry_count
);

    mhpq_pkg::cmd_t  cmd;
    mhpq_pkg::stat_t stat;

    // Controller: walks the sift one level per read and compare state, holds a
    // finished word until the output register is free. The next word is taken while
    // the previous result waits in the output register; a second finished
    // word then holds off the input until that result is accepted.
    mhpq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // Datapath: heap memory with two registered read ports, hole-based sift
    // (the moving key stays in a register and is written once at its place).
    mhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .opcode      (opcode),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .top_value   (top_value),
        .top_valid   (top_valid),
        .entry_count (entry_count)
    );

endmodule

@@ tb/max_heap_priority_queue_top_tb.sv @@
// Self-checking testbench for max_heap_priority_queue_top: directed and random
// insert/remove words, checked against a heap predictor in a scoreboard class.
// Depends on mhpq_pkg and the max_heap_priority_queue_top RTL.
module max_heap_priority_queue_top_tb;

    localparam int CAP         = mhpq_pkg::DEF_CAPACITY;
    localparam int CNT_W       = $clog2(CAP + 1);
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;
    localparam int DRAIN_LIMIT = 20000;
    localparam int RUN_LIMIT   = 1600000;

    typedef struct {
        logic [mhpq_pkg::STATUS_W-1:0]     status;
        logic signed [mhpq_pkg::KEY_W-1:0] top_value;
        logic                              top_valid;
        logic [CNT_W-1:0]                  entry_count;
    } heap_result_t;

    // Heap predictor plus the queue of result words it still expects.
    class heap_scoreboard;
        logic signed [mhpq_pkg::KEY_W-1:0] keys [CAP];
        int unsigned                       fill = 0;
        heap_result_t                      pending_results [$];
        int                                errors = 0;

        // Apply one accepted request word to the heap; queue the result it yields.
        function void apply_request(logic op, logic signed [mhpq_pkg::KEY_W-1:0] key);
            heap_result_t                      r;
            int unsigned                       pos;
            int unsigned                       up;
            int unsigned                       best;
            int unsigned                       lc;
            int unsigned                       rc;
            logic signed [mhpq_pkg::KEY_W-1:0] t;
            bit                                settled;
            r.status = mhpq_pkg::STATUS_DONE;
            if (op == mhpq_pkg::OP_INSERT)
            begin
                if (fill >= CAP)
                begin
                    r.status = mhpq_pkg::STATUS_FULL;
                end
                else
                begin
                    keys[fill] = key;
                    pos = fill;
                    settled = 1'b0;
                    // climb while strictly greater than the parent
                    while (pos > 0 && !settled)
                    begin
                        up = (pos - 1) / 2;
                        if (keys[pos] > keys[up])
                        begin
                            t = keys[pos];
                            keys[pos] = keys[up];
                            keys[up] = t;
                            pos = up;
                        end
                        else
                        begin
                            settled = 1'b1;
                        end
                    end
                    fill++;
                end
            end
            else if (fill == 0)
            begin
                r.status = mhpq_pkg::STATUS_EMPTY;
            end
            else
            begin
                fill--;
                keys[0] = keys[fill];
                pos = 0;
                settled = 1'b0;
                // descend; left child wins a tie between children
                while (!settled)
                begin
                    best = pos;
                    lc = 2 * pos + 1;
                    rc = 2 * pos + 2;
                    if (lc < fill && keys[lc] > keys[best])
                        best = lc;
                    if (rc < fill && keys[rc] > keys[best])
                        best = rc;
                    if (best == pos)
                    begin
                        settled = 1'b1;
                    end
                    else
                    begin
                        t = keys[pos];
                        keys[pos] = keys[best];
                        keys[best] = t;
                        pos = best;
                    end
                end
            end
            r.top_valid   = (fill > 0);
            r.top_value   = (fill > 0) ? keys[0] : '0;
            r.entry_count = fill[CNT_W-1:0];
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, longint expd, longint act);
            if (expd != act)
            begin
                errors++;
                $display("%0t mismatch on %s: expected %0d actual %0d",
                         $time, name, expd, act);
            end
        endfunction

        // Check one accepted result word against the oldest expectation.
        function void check_result(logic [mhpq_pkg::STATUS_W-1:0] st,
                                   logic signed [mhpq_pkg::KEY_W-1:0] tv,
                                   logic tval, logic [CNT_W-1:0] cnt);
            heap_result_t r;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result word: status %0d top %0d count %0d",
                         $time, st, tv, cnt);
            end
            else
            begin
                r = pending_results.pop_front();
                compare_field("status", r.status, st);
                compare_field("top_value", r.top_value, tv);
                compare_field("top_valid", r.top_valid, tval);
                compare_field("entry_count", r.entry_count, cnt);
            end
        endfunction

        function int pending_size();
            return pending_results.size();
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic                              opcode = mhpq_pkg::OP_INSERT;
    logic signed [mhpq_pkg::KEY_W-1:0] value = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [mhpq_pkg::STATUS_W-1:0]     status;
    logic signed [mhpq_pkg::KEY_W-1:0] top_value;
    logic                              top_valid;
    logic [CNT_W-1:0]                  entry_count;

    heap_scoreboard sb = new;

    // Idling controls, set by the main sequence per phase
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;

    // Entry count as seen at generation time; steers the fill phase
    int gen_count = 0;

    max_heap_priority_queue_top #(
        .CAPACITY (CAP)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .top_value   (top_value),
        .top_valid   (top_valid),
        .entry_count (entry_count)
    );

    always #2 clk = ~clk;

    // Monitor: sample both handshakes at the edge; check before noting so a
    // result leaving at the same edge as a new word is matched first.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(status, top_value, top_valid, entry_count);
            if (in_valid && in_ready)
                sb.apply_request(opcode, value);
        end
    end

    // Receiver: stall at the phase rate; once, hold off for a long stretch
    // so the block fills up and drops in_ready while words keep coming.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Hard stop in case the block hangs
    initial
    begin
        #RUN_LIMIT;
        $display("== FAIL ==");
        $finish;
    end

    // Mix extremes, a narrow band that makes equal keys likely, and full-range keys.
    function automatic logic signed [mhpq_pkg::KEY_W-1:0] rand_key();
        logic signed [mhpq_pkg::KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0:       k = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            1, 2, 3: k = int'($urandom_range(0, 16)) - 8;
            default: k = $urandom;
        endcase
        return k;
    endfunction

    function automatic logic rand_op(int insert_pct);
        return ($urandom_range(0, 99) < insert_pct) ? mhpq_pkg::OP_INSERT
                                                     : mhpq_pkg::OP_REMOVE;
    endfunction

    // Offer one word after a random gap; hold it until accepted.
    task automatic send_request(input logic op,
                                input logic signed [mhpq_pkg::KEY_W-1:0] key);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= key;
        do
            @(posedge clk);
        while (!in_ready);
        if (op == mhpq_pkg::OP_INSERT && gen_count < CAP)
            gen_count++;
        else if (op == mhpq_pkg::OP_REMOVE && gen_count > 0)
            gen_count--;
    endtask

    task automatic send_mix(input int n, input int insert_pct);
        repeat (n) send_request(rand_op(insert_pct), rand_key());
    endtask

    // Pause the sender until every expected result word has come back.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_size() != 0) @(posedge clk);
    endtask

    initial
    begin
        int full_hits;
        int waited;
        logic op;

        // Hold reset low, then release it at an edge
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: remove on empty, extreme keys, equal keys, drain past empty
        send_request(mhpq_pkg::OP_REMOVE, 32'sh12345678);
        send_request(mhpq_pkg::OP_INSERT, 32'sh7fffffff);
        send_request(mhpq_pkg::OP_INSERT, 32'sh80000000);
        send_request(mhpq_pkg::OP_INSERT, 32'sh00000000);
        send_request(mhpq_pkg::OP_INSERT, -32'sd1);
        send_request(mhpq_pkg::OP_INSERT, 32'sd5);
        send_request(mhpq_pkg::OP_INSERT, 32'sd5);
        send_request(mhpq_pkg::OP_INSERT, 32'sd5);
        send_request(mhpq_pkg::OP_INSERT, 32'sh7fffffff);
        send_request(mhpq_pkg::OP_REMOVE, 32'shffffffff);
        repeat (8) send_request(mhpq_pkg::OP_REMOVE, 32'sd0);
        send_request(mhpq_pkg::OP_REMOVE, 32'sh80000000);
        send_request(mhpq_pkg::OP_INSERT, 32'sd1);
        send_request(mhpq_pkg::OP_REMOVE, 32'sd0);
        wait_all_results();

        // No idling on either side
        send_mix(40, 60);
        wait_all_results();

        // Sender idle most of the time
        send_idle_pct = 82;
        send_mix(30, 50);
        wait_all_results();

        // Receiver stalls most of the time, starting with the long hold-off
        send_idle_pct = 0;
        stall_pct     = 82;
        hold_req      = 1'b1;
        send_mix(30, 50);
        wait_all_results();

        // Both idle a little: fill the heap to capacity, then push past full
        send_idle_pct = 20;
        stall_pct     = 20;
        full_hits     = 0;
        while (full_hits < 12)
        begin
            if (gen_count == CAP)
            begin
                full_hits++;
                op = rand_op(70);
            end
            else
            begin
                op = rand_op(99);
            end
            send_request(op, rand_key());
        end
        wait_all_results();

        // Drain part of the deep heap with the receiver stalling
        send_idle_pct = 0;
        stall_pct     = 82;
        send_mix(30, 30);

        // Let the last words come back, then allow for the block's latency
        in_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (sb.pending_size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending_size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
